// ===== rtl/dibt_pkg.sv =====
package dibt_pkg;

    // field widths fixed by the interface
    localparam int SectorW = 40;
    localparam int CountW  = 16;
    localparam int LenW    = 20;
    localparam int FsecW   = 55;
    localparam int MibW    = 44;
    localparam int StW     = 3;
    localparam int EntryW  = MibW + StW;
    localparam int OffW    = 19;
    localparam int BlkW    = 29;
    localparam int IdxW    = 30;
    localparam int SlotW   = 12;
    localparam int MibShift = 20;

    localparam logic [4:0] BssMin = 5'd11;
    localparam logic [4:0] BssMax = 5'd19;

    // request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // config register indexes
    localparam logic [1:0] CFG_BLOCK_SHIFT = 2'd0;
    localparam logic [1:0] CFG_CHUNK_SHIFT = 2'd1;
    localparam logic [1:0] CFG_HAS_PARENT  = 2'd2;

    // piece actions
    localparam logic [1:0] ACT_ZERO    = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_IO_ERR  = 2'd2;
    localparam logic [1:0] ACT_UNSUPP  = 2'd3;

    // table entry states
    localparam logic [2:0] BST_UNMAPPED = 3'd3;
    localparam logic [2:0] BST_FULL     = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLK,
        ST_IDX,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic s_ready;
        logic shift_blk;
        logic blk_en;
        logic idx_en;
        logic out_load;
    } seq_ctrl_t;

endpackage

// ===== rtl/dibt_table.sv =====
module dibt_table import dibt_pkg::*; #(
    parameter int Depth = 4096,
    parameter int AddrW = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AddrW-1:0]  wr_addr,
    input  logic [EntryW-1:0] wr_data,
    input  logic [AddrW-1:0]  rd_addr,
    output logic [EntryW-1:0] rd_data
);

    logic [EntryW-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/disk_image_block_translate_top.sv =====
// Block allocation table translator. A load request (cmd 0) writes one table
// entry in the cycle it is taken. A read request (cmd 1) is cut at payload
// block boundaries and gives one result per piece: table index, virtual
// sector, file sector, length, action and a last flag. Each piece passes
// ST_BLK (right shift of the sector by the block shift), ST_IDX (the same
// shifter for the bitmap-skip term, the index add and the table read) and
// ST_EMIT (result formed into the output register, waiting while the result
// side stalls). The input is held off until the piece flagged last is loaded;
// a differencing image skips ST_BLK and ST_IDX and gives one refused piece.
// The table is a single memory with one write and one registered read port;
// entries that were never loaded read back as undefined.
module disk_image_block_translate_top import dibt_pkg::*; #(
    parameter int TABLE_DEPTH  = 4096,
    parameter int SECTOR_SHIFT = 9
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [SlotW-1:0]    s_table_slot,
    input  logic [63:0]         s_table_word,
    input  logic [SectorW-1:0]  s_first_sector,
    input  logic [CountW-1:0]   s_sector_count,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [SlotW-1:0]    m_seg_table_index,
    output logic [SectorW-1:0]  m_seg_virtual_sector,
    output logic [FsecW-1:0]    m_seg_file_sector,
    output logic [LenW-1:0]     m_seg_sectors,
    output logic [1:0]          m_seg_action,
    output logic                m_seg_last
);

    localparam int AddrW = $clog2(TABLE_DEPTH);
    localparam int MibSecShift = MibShift - SECTOR_SHIFT;
    localparam logic [31:0] DepthW = 32'(TABLE_DEPTH);

    // configuration
    logic [4:0] bss_reg;
    logic [3:0] crs_reg;
    logic       hpi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bss_reg <= BssMin;
            crs_reg <= 4'd12;
            hpi_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BLOCK_SHIFT: bss_reg <= cfg_data;
                CFG_CHUNK_SHIFT: crs_reg <= cfg_data[3:0];
                CFG_HAS_PARENT:  hpi_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [4:0] bss_eff;
    always_comb begin
        priority if (bss_reg < BssMin) begin
            bss_eff = BssMin;
        end else if (bss_reg > BssMax) begin
            bss_eff = BssMax;
        end else begin
            bss_eff = bss_reg;
        end
    end

    // sequencer state and working registers
    seq_state_t state_reg, state_next;
    seq_ctrl_t  ctrl;

    logic [SectorW-1:0] sector_reg;
    logic [CountW-1:0]  remain_reg;
    logic [BlkW-1:0]    blk_reg;
    logic [OffW-1:0]    off_reg;
    logic [LenW-1:0]    len_reg;
    logic               last_reg;
    logic [IdxW-1:0]    idx_reg;
    logic               oot_reg;

    logic m_valid_reg;
    logic accept;
    logic is_read;
    logic stop;
    logic can_load;

    assign accept   = s_valid && s_ready;
    assign is_read  = (s_cmd == CMD_READ) && (s_sector_count != '0);
    assign can_load = !m_valid_reg || m_ready;

    // shared shifter: sector by block shift, then block number by chunk shift
    logic [SectorW-1:0] shift_in;
    logic [4:0]         shift_amt;
    logic [SectorW-1:0] shift_out;

    assign shift_in  = ctrl.shift_blk ? sector_reg : SectorW'(blk_reg);
    assign shift_amt = ctrl.shift_blk ? bss_eff : {1'b0, crs_reg};
    assign shift_out = shift_in >> shift_amt;

    // piece length within the current block
    logic [LenW-1:0] per_block;
    logic [LenW-1:0] blk_mask;
    logic [OffW-1:0] off_c;
    logic [LenW-1:0] len_blk;

    assign per_block = LenW'(1) << bss_eff;
    assign blk_mask  = per_block - LenW'(1);
    assign off_c     = sector_reg[OffW-1:0] & blk_mask[OffW-1:0];
    assign len_blk   = per_block - LenW'(off_c);

    logic [IdxW-1:0] idx_c;
    assign idx_c = IdxW'(blk_reg) + IdxW'(shift_out[BlkW-1:0]);

    // table
    logic [31:0]       slot_ext;
    logic              tbl_we;
    logic [EntryW-1:0] rd_data;

    assign slot_ext = 32'(s_table_slot);
    assign tbl_we   = accept && (s_cmd == CMD_LOAD) && (slot_ext < DepthW);

    dibt_table #(
        .Depth (TABLE_DEPTH),
        .AddrW (AddrW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (slot_ext[AddrW-1:0]),
        .wr_data ({s_table_word[63:MibShift], s_table_word[StW-1:0]}),
        .rd_addr (idx_c[AddrW-1:0]),
        .rd_data (rd_data)
    );

    // result of the current piece
    logic [MibW-1:0]  mib;
    logic [StW-1:0]   bst;
    logic [FsecW-1:0] fsec_c;
    logic [1:0]       act_c;

    assign mib = rd_data[EntryW-1:StW];
    assign bst = rd_data[StW-1:0];

    always_comb begin
        if (oot_reg || mib == '0) begin
            fsec_c = '0;
        end else begin
            fsec_c = (FsecW'(mib) << MibSecShift) + FsecW'(off_reg);
        end
        priority if (hpi_reg) begin
            act_c = ACT_UNSUPP;
        end else if (oot_reg) begin
            act_c = ACT_IO_ERR;
        end else if (bst <= BST_UNMAPPED) begin
            act_c = ACT_ZERO;
        end else if (bst == BST_FULL) begin
            act_c = ACT_READ;
        end else begin
            act_c = ACT_IO_ERR;
        end
    end

    assign stop = hpi_reg || last_reg || (act_c == ACT_IO_ERR);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_read) begin
                    state_next = hpi_reg ? ST_EMIT : ST_BLK;
                end
            end
            ST_BLK:  state_next = ST_IDX;
            ST_IDX:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (can_load) begin
                    state_next = stop ? ST_IDLE : ST_BLK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: ctrl.s_ready = 1'b1;
            ST_BLK: begin
                ctrl.shift_blk = 1'b1;
                ctrl.blk_en    = 1'b1;
            end
            ST_IDX:  ctrl.idx_en = 1'b1;
            ST_EMIT: ctrl.out_load = can_load;
            default: ;
        endcase
    end

    assign s_ready = ctrl.s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sector_reg <= s_first_sector;
            remain_reg <= s_sector_count;
        end else if (ctrl.out_load) begin
            sector_reg <= sector_reg + SectorW'(len_reg);
            remain_reg <= remain_reg - len_reg[CountW-1:0];
        end
        if (ctrl.blk_en) begin
            blk_reg <= shift_out[BlkW-1:0];
            off_reg <= off_c;
            if (len_blk >= LenW'(remain_reg)) begin
                len_reg  <= LenW'(remain_reg);
                last_reg <= 1'b1;
            end else begin
                len_reg  <= len_blk;
                last_reg <= 1'b0;
            end
        end
        if (ctrl.idx_en) begin
            idx_reg <= idx_c;
            oot_reg <= 32'(idx_c) >= DepthW;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_seg_virtual_sector <= sector_reg;
            m_seg_action         <= act_c;
            m_seg_last           <= stop;
            if (hpi_reg) begin
                m_seg_table_index <= '0;
                m_seg_file_sector <= '0;
                m_seg_sectors     <= '0;
            end else begin
                m_seg_table_index <= idx_reg[SlotW-1:0];
                m_seg_file_sector <= fsec_c;
                m_seg_sectors     <= len_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // a block walk never starts with nothing left to cover
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BLK |-> remain_reg != '0)
    else $error("block walk started with zero sectors left");

    // error and refusal end the request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_seg_action == ACT_IO_ERR || m_seg_action == ACT_UNSUPP)
        |-> m_seg_last)
    else $error("error piece not marked last");

    // every translated piece covers at least one sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_seg_action != ACT_UNSUPP |-> m_seg_sectors != '0)
    else $error("empty piece");

    // a new request is only taken once the previous one has fully left the walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load && !stop |=> state_reg == ST_BLK && !s_ready)
    else $error("walk did not continue after non-final piece");
`endif

endmodule

// ===== test/tb_disk_image_block_translate_top.sv =====
`timescale 1ns / 100ps

import dibt_pkg::*;

localparam int TABLE_SLOTS  = 4096;
localparam int SECTOR_BITS  = 9;
localparam int CYCLE_LIMIT  = 500000;
localparam int REPORT_LIMIT = 60;

// entry states not named in the package
localparam logic [2:0] BST_ABSENT    = 3'd0;
localparam logic [2:0] BST_UNDEFINED = 3'd1;
localparam logic [2:0] BST_ZERO      = 3'd2;
localparam logic [2:0] BST_RSVD4     = 3'd4;
localparam logic [2:0] BST_RSVD5     = 3'd5;
localparam logic [2:0] BST_PARTIAL   = 3'd7;

// index with no register behind it
localparam logic [1:0] CFG_SPARE = 2'd3;

typedef struct packed {
    logic [SlotW-1:0]   tbl_index;
    logic [SectorW-1:0] vsector;
    logic [FsecW-1:0]   fsector;
    logic [LenW-1:0]    sectors;
    logic [1:0]         action;
    logic               last_piece;
} piece_t;

class xlate_scoreboard;
    logic [63:0] alloc_tbl [TABLE_SLOTS];
    bit          loaded [TABLE_SLOTS];
    logic [4:0]  block_shift;
    logic [3:0]  chunk_shift;
    logic        parent;
    piece_t      read_pieces[$];
    piece_t      expected_pieces[$];
    int          loads;
    int          reads;
    int          pieces_checked;
    int          failures;

    function new();
        block_shift = 5'd11;
        chunk_shift = 4'd12;
        parent = 1'b0;
        foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] data);
        case (idx)
            CFG_BLOCK_SHIFT: block_shift = data;
            CFG_CHUNK_SHIFT: chunk_shift = data[3:0];
            CFG_HAS_PARENT:  parent = data[0];
            default: ;
        endcase
    endfunction

    function logic [4:0] eff_shift();
        if (block_shift < BssMin) return BssMin;
        if (block_shift > BssMax) return BssMax;
        return block_shift;
    endfunction

    // fills read_pieces; returns 0 if the walk would touch a slot never loaded
    function bit translate_read(logic [SectorW-1:0] first, logic [CountW-1:0] count);
        logic [SectorW-1:0] sector;
        logic [16:0]        remain;
        logic [4:0]         sh;
        logic [63:0]        per_block, blk, off, idx, len, entry, mib, fsec;
        logic [2:0]         bst;
        piece_t             p;
        bit                 done;
        read_pieces.delete();
        sector = first;
        remain = {1'b0, count};
        if (remain == 0) return 1'b1;
        if (parent) begin
            p = '0;
            p.vsector = first;
            p.action = ACT_UNSUPP;
            p.last_piece = 1'b1;
            read_pieces.push_back(p);
            return 1'b1;
        end
        sh = eff_shift();
        done = 1'b0;
        while (remain != 0 && !done) begin
            per_block = 64'd1 << sh;
            blk = 64'(sector) >> sh;
            off = 64'(sector) & (per_block - 64'd1);
            idx = blk + (blk >> chunk_shift);
            len = per_block - off;
            if (len > remain) len = 64'(remain);
            p = '0;
            p.tbl_index = idx[SlotW-1:0];
            p.vsector = sector;
            p.sectors = len[LenW-1:0];
            p.last_piece = (len == remain);
            if (idx >= TABLE_SLOTS) begin
                p.action = ACT_IO_ERR;
                p.last_piece = 1'b1;
                done = 1'b1;
            end else begin
                if (!loaded[idx]) return 1'b0;
                entry = alloc_tbl[idx];
                mib = entry >> MibShift;
                fsec = (mib == 0) ? 64'd0 : (mib << (MibShift - SECTOR_BITS)) + off;
                p.fsector = fsec[FsecW-1:0];
                bst = entry[2:0];
                if (bst == BST_FULL) begin
                    p.action = ACT_READ;
                end else if (bst <= BST_UNMAPPED) begin
                    p.action = ACT_ZERO;
                end else begin
                    // partial or unknown state ends the request
                    p.action = ACT_IO_ERR;
                    p.last_piece = 1'b1;
                    done = 1'b1;
                end
            end
            read_pieces.push_back(p);
            remain = remain - len[16:0];
            sector = sector + len[SectorW-1:0];
        end
        return 1'b1;
    endfunction

    function void note_request(logic cmd, logic [SlotW-1:0] slot, logic [63:0] word,
                               logic [SectorW-1:0] first, logic [CountW-1:0] count);
        if (cmd == CMD_LOAD) begin
            if (slot < TABLE_SLOTS) begin
                alloc_tbl[slot] = word;
                loaded[slot] = 1'b1;
            end
            loads++;
        end else begin
            void'(translate_read(first, count));
            foreach (read_pieces[i]) expected_pieces.push_back(read_pieces[i]);
            reads++;
        end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (failures < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    function void check_piece(piece_t got);
        piece_t want;
        if (expected_pieces.size() == 0) begin
            if (failures < REPORT_LIMIT)
                $display("%0t: unexpected piece, expected none actual idx %0h sector %0h",
                         $time, got.tbl_index, got.vsector);
            failures++;
            return;
        end
        want = expected_pieces.pop_front();
        pieces_checked++;
        compare("seg_table_index", 64'(want.tbl_index), 64'(got.tbl_index));
        compare("seg_virtual_sector", 64'(want.vsector), 64'(got.vsector));
        compare("seg_file_sector", 64'(want.fsector), 64'(got.fsector));
        compare("seg_sectors", 64'(want.sectors), 64'(got.sectors));
        compare("seg_action", 64'(want.action), 64'(got.action));
        compare("seg_last", 64'(want.last_piece), 64'(got.last_piece));
    endfunction
endclass

module tb_disk_image_block_translate_top;

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [1:0]         cfg_index      = '0;
    logic [4:0]         cfg_data       = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_cmd          = CMD_LOAD;
    logic [SlotW-1:0]   s_table_slot   = '0;
    logic [63:0]        s_table_word   = '0;
    logic [SectorW-1:0] s_first_sector = '0;
    logic [CountW-1:0]  s_sector_count = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [SlotW-1:0]   m_seg_table_index;
    logic [SectorW-1:0] m_seg_virtual_sector;
    logic [FsecW-1:0]   m_seg_file_sector;
    logic [LenW-1:0]    m_seg_sectors;
    logic [1:0]         m_seg_action;
    logic               m_seg_last;

    logic               idle_mode = 1'b1;
    int                 cycle_count = 0;
    xlate_scoreboard    sb;

    disk_image_block_translate_top #(
        .TABLE_DEPTH  (TABLE_SLOTS),
        .SECTOR_SHIFT (SECTOR_BITS)
    ) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_table_slot         (s_table_slot),
        .s_table_word         (s_table_word),
        .s_first_sector       (s_first_sector),
        .s_sector_count       (s_sector_count),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_seg_table_index    (m_seg_table_index),
        .m_seg_virtual_sector (m_seg_virtual_sector),
        .m_seg_file_sector    (m_seg_file_sector),
        .m_seg_sectors        (m_seg_sectors),
        .m_seg_action         (m_seg_action),
        .m_seg_last           (m_seg_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pieces outstanding",
                     cycle_count, sb.expected_pieces.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin : collect
        piece_t got;
        if (aresetn && m_valid && m_ready) begin
            got.tbl_index = m_seg_table_index;
            got.vsector = m_seg_virtual_sector;
            got.fsector = m_seg_file_sector;
            got.sectors = m_seg_sectors;
            got.action = m_seg_action;
            got.last_piece = m_seg_last;
            sb.check_piece(got);
        end
        m_ready <= !idle_mode || ($urandom_range(99) >= 29);
    end

    function automatic logic [63:0] make_word(logic [43:0] mib, logic [2:0] bst);
        return {mib, 17'h0, bst};
    endfunction

    function automatic logic [63:0] rand_entry();
        logic [43:0] mib;
        logic [2:0]  bst;
        int          r;
        r = $urandom_range(99);
        if (r < 50) begin
            bst = BST_FULL;
        end else if (r < 97) begin
            bst = 3'($urandom_range(BST_ABSENT, BST_UNMAPPED));
        end else begin
            case ($urandom_range(2))
                0:       bst = BST_RSVD4;
                1:       bst = BST_RSVD5;
                default: bst = BST_PARTIAL;
            endcase
        end
        case ($urandom_range(7))
            0:       mib = '0;
            1:       mib = '1;
            2, 3:    mib = 44'($urandom_range(1, 4096));
            default: mib = 44'({$urandom, $urandom});
        endcase
        return {mib, 17'($urandom), bst};
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge aclk);
    endtask

    // unused upper data bits are filled at random
    task automatic apply_config(logic [4:0] bss, logic [3:0] crs, logic parent);
        write_reg(CFG_SPARE, 5'($urandom));
        write_reg(CFG_BLOCK_SHIFT, bss);
        write_reg(CFG_CHUNK_SHIFT, {1'($urandom), crs});
        write_reg(CFG_HAS_PARENT, {4'($urandom), parent});
    endtask

    task automatic send_request(logic cmd, logic [SlotW-1:0] slot, logic [63:0] word,
                                logic [SectorW-1:0] first, logic [CountW-1:0] count);
        while (idle_mode && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_table_slot <= slot;
        s_table_word <= word;
        s_first_sector <= first;
        s_sector_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(cmd, slot, word, first, count);
    endtask

    // lets the block settle so registers can be rewritten
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_pieces.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // reads aim at loaded slots; a walk that would hit a slot never loaded is redrawn
    task automatic random_read();
        logic [SectorW-1:0] first;
        logic [CountW-1:0]  count;
        logic [63:0]        blk, tgt;
        logic [4:0]         sh;
        bit                 found;
        int                 r;
        found = 1'b0;
        sh = sb.eff_shift();
        for (int tries = 0; tries < 40 && !found; tries++) begin
            r = $urandom_range(19);
            if (r == 0)
                count = '0;
            else if (r < 3)
                count = '1;
            else if (r < 11)
                count = CountW'($urandom_range(1, 4096));
            else
                count = CountW'($urandom_range(1, 65535));
            r = $urandom_range(99);
            if (r < 75) begin
                blk = 64'($urandom_range(0, 63));
                first = SectorW'((blk << sh) + (64'($urandom) & ((64'd1 << sh) - 64'd1)));
            end else if (r < 88) begin
                // land near the top of the table
                tgt = 64'($urandom_range(4064, 4095));
                blk = (tgt << sb.chunk_shift) / ((64'd1 << sb.chunk_shift) + 64'd1);
                first = SectorW'((blk << sh) + (64'($urandom) & ((64'd1 << sh) - 64'd1)));
            end else begin
                first = SectorW'({$urandom, $urandom});
            end
            found = sb.translate_read(first, count);
        end
        if (!found) count = '0;
        send_request(CMD_READ, SlotW'($urandom), {$urandom, $urandom}, first, count);
    endtask

    task automatic random_mix(int n);
        logic [SlotW-1:0] slot;
        int               r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 18) begin
                r = $urandom_range(9);
                if (r < 5)
                    slot = SlotW'($urandom_range(0, 95));
                else if (r < 7)
                    slot = SlotW'($urandom_range(4064, 4095));
                else
                    slot = SlotW'($urandom);
                send_request(CMD_LOAD, slot, rand_entry(), SectorW'({$urandom, $urandom}),
                             CountW'($urandom));
            end else begin
                random_read();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        apply_config(5'd11, 4'd12, 1'b0);
        for (int s = 0; s < 96; s++)
            send_request(CMD_LOAD, SlotW'(s), rand_entry(), '0, '0);
        for (int s = 4064; s < TABLE_SLOTS; s++)
            send_request(CMD_LOAD, SlotW'(s), rand_entry(), '0, '0);

        // one slot per entry state, offsets at their extremes
        send_request(CMD_LOAD, 12'd0, {44'hFFF_FFFF_FFFF, 17'h1FFFF, BST_FULL}, '0, '0);
        send_request(CMD_LOAD, 12'd1, make_word(44'd0, BST_ZERO), '0, '0);
        send_request(CMD_LOAD, 12'd2, make_word(44'd5, BST_ABSENT), '0, '0);
        send_request(CMD_LOAD, 12'd3, make_word(44'd7, BST_UNDEFINED), '0, '0);
        send_request(CMD_LOAD, 12'd4, make_word(44'd1, BST_UNMAPPED), '0, '0);
        send_request(CMD_LOAD, 12'd5, make_word(44'd3, BST_PARTIAL), '0, '0);
        send_request(CMD_LOAD, 12'd6, make_word(44'd9, BST_RSVD4), '0, '0);
        send_request(CMD_LOAD, 12'd7, make_word(44'd11, BST_RSVD5), '0, '0);
        send_request(CMD_LOAD, 12'd4095, make_word(44'd2, BST_FULL), '0, '0);

        send_request(CMD_READ, '0, '0, 40'd0, 16'd1);
        send_request(CMD_READ, '0, '0, 40'd2047, 16'd2);
        send_request(CMD_READ, '0, '0, 40'd4096, 16'd1);
        send_request(CMD_READ, '0, '0, 40'd6244, 16'd50);
        send_request(CMD_READ, '0, '0, 40'd8192, 16'd2048);
        send_request(CMD_READ, '0, '0, 40'd10247, 16'd9);
        send_request(CMD_READ, '0, '0, 40'd12288, 16'd1);
        send_request(CMD_READ, '0, '0, 40'd14336, 16'd3);
        send_request(CMD_READ, '0, '0, 40'd0, 16'hFFFF);
        send_request(CMD_READ, '0, '0, 40'd18431, 16'hFFFF);
        send_request(CMD_READ, '0, '0, 40'd100, 16'd0);
        send_request(CMD_READ, '0, '0, '1, 16'hFFFF);
        // last slot, then past the end of the table
        send_request(CMD_READ, '0, '0, 40'(4095) << 11, 16'd4096);
        random_mix(15);
        drain();

        apply_config(5'd19, 4'd4, 1'b0);
        random_mix(15);
        drain();
        // chunk shift of zero doubles every index
        apply_config(5'd14, 4'd0, 1'b0);
        random_mix(15);
        drain();
        // block shifts outside their range are clamped
        apply_config(5'd5, 4'd15, 1'b0);
        random_mix(15);
        drain();
        apply_config(5'd31, 4'd7, 1'b0);
        random_mix(15);
        drain();
        // differencing image refuses reads
        apply_config(5'd12, 4'd6, 1'b1);
        random_mix(15);
        drain();
        idle_mode <= 1'b0;
        apply_config(5'd13, 4'd9, 1'b0);
        random_mix(15);
        drain();
        idle_mode <= 1'b1;
        apply_config(5'd11, 4'd12, 1'b0);
        random_mix(15);
        drain();

        $display("%0d table loads and %0d read requests sent, %0d pieces compared",
                 sb.loads, sb.reads, sb.pieces_checked);
        $display("covered block shifts 11 to 19 with clamping, chunk shifts 0 to 15 and a parent image");
        if (sb.failures == 0 && sb.expected_pieces.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
